// ----- rtl/core/u16u8_pkg.sv -----
`default_nettype none

package u16u8_pkg;

  // default depth of the queue between the front and the back
  localparam int QueueDepth = 2;

  // most byte results one item can cause (replacement plus a three-byte unit)
  localparam int MaxBytes = 6;
  localparam int CntW     = $clog2(MaxBytes + 1);

  // input item kinds
  localparam logic KIND_UNIT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // U+FFFD as UTF-8, first byte in the low bits
  localparam logic [23:0] REPL_BYTES = 24'hBDBFEF;

  // surrogate prefixes on the top six bits of a unit
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  // one classified item, as handed from the front to the back
  typedef struct packed {
    logic [MaxBytes*8-1:0] bytes;   // byte 0 in the low bits
    logic [CntW-1:0]       nbytes;
    logic                  eov;
    logic [31:0]           total;
  } rec_t;

endpackage

`default_nettype wire

// ----- rtl/core/u16u8_front.sv -----
`default_nettype none

module u16u8_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_kind,
  input  wire logic [15:0]      in_code_unit,
  input  wire logic             q_full,
  output logic                  push,
  output u16u8_pkg::rec_t       push_rec
);

  logic        held_r, held_nxt;
  logic [9:0]  hbits_r, hbits_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  logic        is_high, is_low;
  logic        flush, lone, accept;
  logic [31:0] body;
  logic [2:0]  body_n;
  logic [23:0] bmp_bytes;
  logic [2:0]  bmp_n;
  logic [20:0] cp;
  logic [31:0] pair_bytes;
  logic        eov;
  logic [u16u8_pkg::CntW-1:0] nbytes;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_high  = (in_code_unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
  assign is_low   = (in_code_unit[15:10] == u16u8_pkg::LOW_SURR_TAG);

  // plain unit encoding, one to three bytes
  always_comb begin
    if (in_code_unit < 16'h0080) begin
      bmp_bytes = {16'h0000, 1'b0, in_code_unit[6:0]};
      bmp_n     = 3'd1;
    end else if (in_code_unit < 16'h0800) begin
      bmp_bytes = {8'h00, 2'b10, in_code_unit[5:0], 3'b110, in_code_unit[10:6]};
      bmp_n     = 3'd2;
    end else begin
      bmp_bytes = {2'b10, in_code_unit[5:0], 2'b10, in_code_unit[11:6],
                   4'b1110, in_code_unit[15:12]};
      bmp_n     = 3'd3;
    end
  end

  // surrogate pair to a four-byte sequence
  assign cp = 21'h10000 + {1'b0, hbits_r, in_code_unit[9:0]};
  assign pair_bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};

  always_comb begin
    held_nxt  = held_r;
    hbits_nxt = hbits_r;
    flush     = 1'b0;
    lone      = 1'b0;
    eov       = 1'b0;
    body      = '0;
    body_n    = 3'd0;
    if (in_kind == u16u8_pkg::KIND_END) begin
      flush     = held_r;
      held_nxt  = 1'b0;
      hbits_nxt = '0;
      eov       = 1'b1;
    end else if (held_r && is_low) begin
      body      = pair_bytes;
      body_n    = 3'd4;
      held_nxt  = 1'b0;
      hbits_nxt = '0;
    end else begin
      flush     = held_r;
      held_nxt  = 1'b0;
      hbits_nxt = '0;
      if (is_high) begin
        held_nxt  = 1'b1;
        hbits_nxt = in_code_unit[9:0];
      end else if (is_low) begin
        lone   = 1'b1;
        body   = {8'h00, u16u8_pkg::REPL_BYTES};
        body_n = 3'd3;
      end else begin
        body   = {8'h00, bmp_bytes};
        body_n = bmp_n;
      end
    end
  end

  // at most one replacement per item, saturating
  assign cnt_nxt = ((flush || lone) && (cnt_r != 32'hFFFF_FFFF)) ? cnt_r + 32'd1 : cnt_r;

  always_comb begin
    if (flush) begin
      push_rec.bytes = {body[23:0], u16u8_pkg::REPL_BYTES};
      nbytes         = u16u8_pkg::CntW'(body_n + 3'd3);
    end else begin
      push_rec.bytes = {16'h0000, body};
      nbytes         = u16u8_pkg::CntW'(body_n);
    end
    push_rec.nbytes = nbytes;
    push_rec.eov    = eov;
    push_rec.total  = cnt_nxt;
  end

  // a held high surrogate with nothing flushed gives no record
  assign push = accept && ((nbytes != '0) || eov);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      hbits_r <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      held_r  <= held_nxt;
      hbits_r <= hbits_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u16u8_queue.sv -----
`default_nettype none

module u16u8_queue #(
  parameter int Depth = u16u8_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire u16u8_pkg::rec_t push_rec,
  input  wire logic            pop,
  output u16u8_pkg::rec_t      head_rec,
  output logic                 not_empty,
  output logic                 full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntQW = $clog2(Depth + 1);

  u16u8_pkg::rec_t mem [Depth];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntQW-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CntQW'(Depth));
  assign head_rec  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u16u8_back.sv -----
`default_nettype none

module u16u8_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire u16u8_pkg::rec_t head_rec,
  input  wire logic            q_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_has_byte,
  output logic                 out_end_of_value,
  output logic                 out_last,
  output logic [31:0]          out_replaced_total
);

  localparam int CW = u16u8_pkg::CntW;

  logic          valid_r;
  logic [7:0]    byte_r, byte_nxt;
  logic          has_r, has_nxt;
  logic          eov_r, eov_nxt;
  logic          last_r, last_nxt;
  logic [31:0]   total_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] n_res;
  logic          adv;

  assign n_res = head_rec.nbytes + CW'(head_rec.eov);
  assign adv   = !valid_r || out_ready;
  assign pop   = adv && q_valid && last_nxt;

  always_comb begin
    if (idx_r < head_rec.nbytes) begin
      byte_nxt = head_rec.bytes[{idx_r, 3'b000} +: 8];
      has_nxt  = 1'b1;
      eov_nxt  = 1'b0;
    end else begin
      byte_nxt = 8'h00;
      has_nxt  = 1'b0;
      eov_nxt  = 1'b1;
    end
    last_nxt = (idx_r == n_res - 1'b1);
    idx_nxt  = last_nxt ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (adv) begin
      valid_r <= q_valid;
      if (q_valid) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      byte_r  <= byte_nxt;
      has_r   <= has_nxt;
      eov_r   <= eov_nxt;
      last_r  <= last_nxt;
      total_r <= head_rec.total;
    end
  end

  assign out_valid          = valid_r;
  assign out_byte           = byte_r;
  assign out_has_byte       = has_r;
  assign out_end_of_value   = eov_r;
  assign out_last           = last_r;
  assign out_replaced_total = total_r;

`ifndef SYNTH
  // every queued record carries at least one result
  a_rec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (n_res != '0))
    else $error("queued record with no results");

  // byte index never runs past the record
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (idx_r < n_res))
    else $error("byte index beyond record");

  // index is back at zero between records
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> (idx_r == '0))
    else $error("byte index not cleared while queue empty");

  // an end marker is always the last result of its item
  a_eov_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && eov_r |-> last_r)
    else $error("end marker not last");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/utf16le_to_utf8_value_transcoder.sv -----
`default_nettype none

// latency: a result passes through the record queue and then the back's output register after its input transfer
// throughput: one result per cycle while out_ready is high; an item gives 0 to 6 results
//   (none for a held high surrogate, 3 for a typical BMP unit), sent by the single byte lane of the back serializer
// the front takes a new item every cycle while the record queue has room
// reset: synchronous active-low rst_n clears the held surrogate, the replacement
//   count, the queue and the output stage

module utf16le_to_utf8_value_transcoder #(
  parameter int QueueDepth = u16u8_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [15:0] in_code_unit,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_end_of_value,
  output logic             out_last,
  output logic [31:0]      out_replaced_total
);

  // front to queue
  logic            push;
  u16u8_pkg::rec_t push_rec;
  logic            q_full;

  // queue to back
  u16u8_pkg::rec_t head_rec;
  logic            q_valid;
  logic            pop;

  // front: classifies each unit, pairs surrogates, keeps the replacement count
  // and packs every byte the item causes into one record
  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_code_unit (in_code_unit),
    .q_full       (q_full),
    .push         (push),
    .push_rec     (push_rec)
  );

  // short record queue so the front keeps taking items while the back drains
  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head_rec  (head_rec),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // back: serializes a record one byte per transfer into the output register,
  // then the end marker when the record closes a value
  u16u8_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_rec           (head_rec),
    .q_valid            (q_valid),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_has_byte       (out_has_byte),
    .out_end_of_value   (out_end_of_value),
    .out_last           (out_last),
    .out_replaced_total (out_replaced_total)
  );

endmodule

`default_nettype wire

// ----- bench/utf16_utf8_checker.sv -----
`timescale 1ns / 1ps

module utf16_utf8_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_kind,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [7:0]  out_byte,
  input  wire logic        out_has_byte,
  input  wire logic        out_end_of_value,
  input  wire logic        out_last,
  input  wire logic [31:0] out_replaced_total,
  output int               errors,
  output int               pending,
  output int               items_seen,
  output int               results_seen,
  output logic [31:0]      replaced
);

  typedef struct packed {
    logic [7:0]  octet;
    logic        has_byte;
    logic        eov;
    logic        is_last;
    logic [31:0] total;
  } utf8_beat_t;

  utf8_beat_t utf8_expected_q[$];
  utf8_beat_t item_beats[$];

  logic        held_v;
  logic [9:0]  held_bits;
  logic [31:0] repl_cnt;

  assign replaced = repl_cnt;

  function automatic void add_octet(logic [7:0] o);
    utf8_beat_t b;
    b = '0;
    b.octet = o;
    b.has_byte = 1'b1;
    item_beats.push_back(b);
  endfunction

  // U+FFFD, saturating count
  function automatic void add_fffd();
    add_octet(u16u8_pkg::REPL_BYTES[7:0]);
    add_octet(u16u8_pkg::REPL_BYTES[15:8]);
    add_octet(u16u8_pkg::REPL_BYTES[23:16]);
    if (repl_cnt != 32'hFFFF_FFFF) repl_cnt = repl_cnt + 32'd1;
  endfunction

  // one unit with nothing held
  function automatic void encode_bmp(logic [15:0] u);
    if (u < 16'h0080) begin
      add_octet({1'b0, u[6:0]});
    end else if (u < 16'h0800) begin
      add_octet({3'b110, u[10:6]});
      add_octet({2'b10, u[5:0]});
    end else if (u[15:10] == u16u8_pkg::HIGH_SURR_TAG) begin
      held_v = 1'b1;
      held_bits = u[9:0];
    end else if (u[15:10] == u16u8_pkg::LOW_SURR_TAG) begin
      add_fffd();
    end else begin
      add_octet({4'b1110, u[15:12]});
      add_octet({2'b10, u[11:6]});
      add_octet({2'b10, u[5:0]});
    end
  endfunction

  function automatic void predict_utf8(logic k, logic [15:0] u);
    utf8_beat_t b;
    logic [20:0] cp;
    item_beats.delete();
    if (k == u16u8_pkg::KIND_END) begin
      if (held_v) begin
        held_v = 1'b0;
        held_bits = '0;
        add_fffd();
      end
      b = '0;
      b.eov = 1'b1;
      item_beats.push_back(b);
    end else if (held_v && u[15:10] == u16u8_pkg::LOW_SURR_TAG) begin
      cp = 21'h10000 + {1'b0, held_bits, u[9:0]};
      held_v = 1'b0;
      held_bits = '0;
      add_octet({5'b11110, cp[20:18]});
      add_octet({2'b10, cp[17:12]});
      add_octet({2'b10, cp[11:6]});
      add_octet({2'b10, cp[5:0]});
    end else begin
      if (held_v) begin
        held_v = 1'b0;
        held_bits = '0;
        add_fffd();
      end
      encode_bmp(u);
    end
    // count is the one after the whole item, on every result of it
    foreach (item_beats[i]) begin
      b = item_beats[i];
      b.total = repl_cnt;
      b.is_last = (i == item_beats.size() - 1);
      utf8_expected_q.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    utf8_beat_t want;
    utf8_beat_t got;
    if (!rst_n) begin
      held_v = 1'b0;
      held_bits = '0;
      repl_cnt = '0;
      utf8_expected_q.delete();
      errors = 0;
      items_seen = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.octet = out_byte;
        got.has_byte = out_has_byte;
        got.eov = out_end_of_value;
        got.is_last = out_last;
        got.total = out_replaced_total;
        results_seen++;
        if (utf8_expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: byte=%h has=%b eov=%b last=%b total=%0d",
                   $time, got.octet, got.has_byte, got.eov, got.is_last, got.total);
        end else begin
          want = utf8_expected_q.pop_front();
          if (want !== got) begin
            errors++;
            $display("%0t: mismatch expected byte=%h has=%b eov=%b last=%b total=%0d",
                     $time, want.octet, want.has_byte, want.eov, want.is_last, want.total);
            $display("%0t:          actual   byte=%h has=%b eov=%b last=%b total=%0d",
                     $time, got.octet, got.has_byte, got.eov, got.is_last, got.total);
          end
        end
      end
      if (in_valid && in_ready) begin
        items_seen++;
        predict_utf8(in_kind, in_code_unit);
      end
    end
    pending = utf8_expected_q.size();
  end

endmodule

// ----- bench/utf16le_to_utf8_value_transcoder_tb.sv -----
`timescale 1ns / 1ps

module utf16le_to_utf8_value_transcoder_tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [15:0] in_code_unit;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_has_byte;
  logic        out_end_of_value;
  logic        out_last;
  logic [31:0] out_replaced_total;

  int          errors;
  int          pending;
  int          items_seen;
  int          results_seen;
  logic [31:0] replaced;

  // transfers accepted so far, as seen by the sender
  int n_sent;
  // window in which neither side idles
  logic quiet;
  bit hold_done;

  utf16le_to_utf8_value_transcoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_code_unit      (in_code_unit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_has_byte      (out_has_byte),
    .out_end_of_value  (out_end_of_value),
    .out_last          (out_last),
    .out_replaced_total(out_replaced_total)
  );

  utf16_utf8_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_code_unit      (in_code_unit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_has_byte      (out_has_byte),
    .out_end_of_value  (out_end_of_value),
    .out_last          (out_last),
    .out_replaced_total(out_replaced_total),
    .errors            (errors),
    .pending           (pending),
    .items_seen        (items_seen),
    .results_seen      (results_seen),
    .replaced          (replaced)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one item and hold it until the transfer happens
  // called at a rising edge, returns at the edge of the transfer
  task automatic send_item(input logic k, input logic [15:0] cu);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_code_unit <= cu;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // sender: directed corners first, then mostly well-formed text
  initial begin
    int pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= u16u8_pkg::KIND_UNIT;
    in_code_unit <= '0;
    n_sent = 0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // range edges of the one, two and three byte forms, NUL included
    send_item(u16u8_pkg::KIND_UNIT, 16'h0000);
    send_item(u16u8_pkg::KIND_UNIT, 16'h007F);
    send_item(u16u8_pkg::KIND_UNIT, 16'h0080);
    send_item(u16u8_pkg::KIND_UNIT, 16'h07FF);
    send_item(u16u8_pkg::KIND_UNIT, 16'h0800);
    send_item(u16u8_pkg::KIND_UNIT, 16'hD7FF);
    send_item(u16u8_pkg::KIND_UNIT, 16'hE000);
    send_item(u16u8_pkg::KIND_UNIT, 16'hFFFF);
    // lowest and highest surrogate pairs
    send_item(u16u8_pkg::KIND_UNIT, 16'hD800);
    send_item(u16u8_pkg::KIND_UNIT, 16'hDC00);
    send_item(u16u8_pkg::KIND_UNIT, 16'hDBFF);
    send_item(u16u8_pkg::KIND_UNIT, 16'hDFFF);
    // lone low surrogates
    send_item(u16u8_pkg::KIND_UNIT, 16'hDC00);
    send_item(u16u8_pkg::KIND_UNIT, 16'hDFFF);
    // high after high, then a three byte unit behind a held high: six results
    send_item(u16u8_pkg::KIND_UNIT, 16'hD800);
    send_item(u16u8_pkg::KIND_UNIT, 16'hDBFF);
    send_item(u16u8_pkg::KIND_UNIT, 16'h20AC);
    // held high flushed by the end of the value
    send_item(u16u8_pkg::KIND_UNIT, 16'hD83D);
    send_item(u16u8_pkg::KIND_END, 16'h0000);
    // empty value, code unit on an end item is ignored
    send_item(u16u8_pkg::KIND_END, 16'hFFFF);
    send_item(u16u8_pkg::KIND_END, 16'h5A5A);

    while (n_sent < 320) begin
      quiet = (n_sent >= 150 && n_sent < 230);
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_item(u16u8_pkg::KIND_UNIT, 16'($urandom_range(16'h0000, 16'h007F)));
      end else if (pick < 40) begin
        send_item(u16u8_pkg::KIND_UNIT, 16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (pick < 60) begin
        // three byte range, skipping the surrogate block
        if ($urandom_range(1) == 0) begin
          send_item(u16u8_pkg::KIND_UNIT, 16'($urandom_range(16'h0800, 16'hD7FF)));
        end else begin
          send_item(u16u8_pkg::KIND_UNIT, 16'($urandom_range(16'hE000, 16'hFFFF)));
        end
      end else if (pick < 75) begin
        send_item(u16u8_pkg::KIND_UNIT, 16'($urandom_range(16'hD800, 16'hDBFF)));
        send_item(u16u8_pkg::KIND_UNIT, 16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (pick < 85) begin
        send_item(u16u8_pkg::KIND_END, 16'($urandom));
      end else if (pick < 90) begin
        // lone high, whatever follows decides its fate
        send_item(u16u8_pkg::KIND_UNIT, 16'($urandom_range(16'hD800, 16'hDBFF)));
      end else if (pick < 94) begin
        send_item(u16u8_pkg::KIND_UNIT, 16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else begin
        send_item(u16u8_pkg::KIND_UNIT, 16'($urandom));
      end
    end
    quiet = 1'b0;
    // close the last value so nothing stays held
    send_item(u16u8_pkg::KIND_END, 16'($urandom));
    in_valid <= 1'b0;

    // let the checker see the last transfer before polling its queue
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // drain margin: a stray result would show up here
    repeat (20) @(posedge clk);

    $display("ran %0d input items in values, checked %0d results", items_seen, results_seen);
    $display("%0d surrogates replaced, %0d mismatches", replaced, errors);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    out_ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && n_sent >= 40) begin
        out_ready <= 1'b0;
        // long enough to fill the queue and back up the input
        repeat (80) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 17);
        @(posedge clk);
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
